/* sv/sge_pkg.sv */
// Shared types and constants for the staggered glyph ease-out pipeline.
package sge_pkg;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [15:0] STAGGER_CAP = 16'd62259;

  // Register indexes on the config write port.
  typedef enum logic [2:0] {
    CFG_DURATION    = 3'd0,
    CFG_STAGGER     = 3'd1,
    CFG_TRAILING    = 3'd2,
    CFG_DELTA       = 3'd3,
    CFG_MANUAL_EN   = 3'd4,
    CFG_MANUAL_PROG = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]        duration_us;
    logic [15:0]        stagger_q16;
    logic [15:0]        trailing_q8_8;
    logic signed [23:0] slide_delta;
    logic               manual_enable;
    logic [16:0]        manual_progress;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    duration_us:     32'd1,
    stagger_q16:     16'd0,
    trailing_q8_8:   16'd256,
    slide_delta:     24'sd0,
    manual_enable:   1'b0,
    manual_progress: 17'd0
  };

  // State carried through the two parallel restoring dividers.
  typedef struct packed {
    logic [31:0] dur;    // base divisor
    logic [31:0] brem;   // base partial remainder
    logic [15:0] bq;     // base quotient bits so far
    logic        bfull;  // base progress is exactly one
    logic [60:0] den;    // glyph divisor
    logic [60:0] grem;   // glyph partial remainder
    logic [15:0] gq;     // glyph quotient bits so far
    logic        gzero;  // glyph not started yet
    logic        gfull;  // glyph already finished
  } div_t;

endpackage

/* sv/sge_front.sv */
// Front stages: time select and clamp, span products and glyph start compare.
module sge_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sge_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   time_i,
  input  logic [11:0]   idx_i,
  input  logic [12:0]   cnt_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sge_pkg::div_t out_o
);
  import sge_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  // stage 1
  logic [31:0] dur;
  logic [15:0] stg;
  logic [16:0] istg, mp;
  logic [48:0] mp_prod;
  logic        gl_en;
  logic [31:0] s1_tm_d, s1_tm_q, s1_dur_q;
  logic [47:0] s1_ds_d, s1_ds_q, s1_di_d, s1_di_q;
  logic [12:0] s1_c1_d, s1_c1_q;
  logic [11:0] s1_idx_q;
  logic        s1_glen_q;
  // stage 2
  logic [31:0] s2_tm_d, s2_tm_q, s2_dur_q;
  logic [59:0] s2_b_d, s2_b_q;
  logic [60:0] s2_den_d, s2_den_q;
  logic [12:0] s2_c1_q;
  // stage 3
  logic [44:0] s3_prod;
  logic [60:0] s3_a_d, s3_a_q, s3_den_q;
  logic [59:0] s3_b_q;
  logic [31:0] s3_dur_q, s3_brem_q;
  logic        s3_bfull_q;
  // stage 4
  logic [60:0] s4_diff_d, s4_diff_q, s4_den_q;
  logic        s4_le_d, s4_le_q;
  logic [31:0] s4_dur_q, s4_brem_q;
  logic        s4_bfull_q;
  // stage 5
  div_t        s5_d, s5_q;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    dur     = (cfg_i.duration_us == 32'd0) ? 32'd1 : cfg_i.duration_us;
    stg     = (cfg_i.stagger_q16 > STAGGER_CAP) ? STAGGER_CAP : cfg_i.stagger_q16;
    istg    = ONE_Q16 - {1'b0, stg};
    mp      = (cfg_i.manual_progress > ONE_Q16) ? ONE_Q16 : cfg_i.manual_progress;
    mp_prod = 49'(dur) * 49'(mp);
    gl_en   = cnt_i > 13'd1;
    s1_tm_d = cfg_i.manual_enable ? mp_prod[47:16] : time_i;
    s1_ds_d = 48'(dur) * 48'(stg);
    s1_di_d = 48'(dur) * 48'(istg);
    s1_c1_d = gl_en ? (cnt_i - 13'd1) : 13'd1;
  end

  always_comb begin
    s2_tm_d  = (s1_tm_q > s1_dur_q) ? s1_dur_q : s1_tm_q;
    s2_b_d   = s1_glen_q ? (60'(s1_ds_q) * 60'(s1_idx_q)) : 60'd0;
    s2_den_d = 61'(s1_di_q) * 61'(s1_c1_q);
  end

  always_comb begin
    s3_prod = 45'(s2_tm_q) * 45'(s2_c1_q);
    s3_a_d  = {s3_prod, 16'd0};
  end

  always_comb begin
    s4_le_d   = s3_a_q <= 61'(s3_b_q);
    s4_diff_d = s3_a_q - 61'(s3_b_q);
  end

  always_comb begin
    s5_d       = '0;
    s5_d.dur   = s4_dur_q;
    s5_d.brem  = s4_brem_q;
    s5_d.bfull = s4_bfull_q;
    s5_d.den   = s4_den_q;
    s5_d.grem  = s4_diff_q;
    s5_d.gzero = s4_le_q;
    s5_d.gfull = !s4_le_q && (s4_diff_q >= s4_den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_tm_q   <= s1_tm_d;
      s1_dur_q  <= dur;
      s1_ds_q   <= s1_ds_d;
      s1_di_q   <= s1_di_d;
      s1_c1_q   <= s1_c1_d;
      s1_idx_q  <= idx_i;
      s1_glen_q <= gl_en;
    end
    if (en2 && v1_q) begin
      s2_tm_q  <= s2_tm_d;
      s2_dur_q <= s1_dur_q;
      s2_b_q   <= s2_b_d;
      s2_den_q <= s2_den_d;
      s2_c1_q  <= s1_c1_q;
    end
    if (en3 && v2_q) begin
      s3_a_q     <= s3_a_d;
      s3_b_q     <= s2_b_q;
      s3_den_q   <= s2_den_q;
      s3_dur_q   <= s2_dur_q;
      s3_brem_q  <= s2_tm_q;
      s3_bfull_q <= s2_tm_q == s2_dur_q;
    end
    if (en4 && v3_q) begin
      s4_le_q    <= s4_le_d;
      s4_diff_q  <= s4_diff_d;
      s4_den_q   <= s3_den_q;
      s4_dur_q   <= s3_dur_q;
      s4_brem_q  <= s3_brem_q;
      s4_bfull_q <= s3_bfull_q;
    end
    if (en5 && v4_q) begin
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_o       = s5_q;

endmodule

/* sv/sge_div_stage.sv */
// One restoring division step for both the base and the glyph progress.
module sge_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sge_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sge_pkg::div_t out_o
);
  import sge_pkg::*;

  logic        v_q, en;
  logic [61:0] g_sh, g_sub;
  logic [32:0] b_sh, b_sub;
  logic        g_ge, b_ge;
  div_t        st_d, st_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    g_sh    = {in_i.grem, 1'b0};
    g_sub   = g_sh - {1'b0, in_i.den};
    g_ge    = g_sh >= {1'b0, in_i.den};
    b_sh    = {in_i.brem, 1'b0};
    b_sub   = b_sh - {1'b0, in_i.dur};
    b_ge    = b_sh >= {1'b0, in_i.dur};
    st_d      = in_i;
    st_d.grem = g_ge ? g_sub[60:0] : g_sh[60:0];
    st_d.gq   = {in_i.gq[14:0], g_ge};
    st_d.brem = b_ge ? b_sub[31:0] : b_sh[31:0];
    st_d.bq   = {in_i.bq[14:0], b_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      st_q <= st_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = st_q;

endmodule

/* sv/sge_back.sv */
// Back stages: ease-out cubic of both progresses, offset product, round and saturate.
module sge_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sge_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sge_pkg::div_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   glyph_dx_o,
  output logic [16:0]   glyph_alpha_o,
  output logic          moved_o
);
  import sge_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  logic [16:0] tb, tg;
  logic [16:0] s1_ib_q, s1_ig_q, s2_ib_q, s2_ig_q;
  logic [33:0] s2_sb_q, s2_sg_q;
  logic [50:0] s3_cb_q, s3_cg_q;
  logic [50:0] rb, rg;
  logic [16:0] s4_eb_q, s4_eg_q;
  logic        s5_neg_d;
  logic [16:0] s5_mag_d, s5_mag_q, s5_eg_q;
  logic [23:0] dbits, s5_dmag_d, s5_dmag_q;
  logic        s5_neg_q;
  logic [40:0] s6_p_q;
  logic        s6_neg_q;
  logic [16:0] s6_eg_q;
  logic [56:0] s7_p_q;
  logic        s7_neg_q;
  logic [16:0] s7_eg_q;
  logic [57:0] rsum;
  logic [33:0] qmag, qneg;
  logic [31:0] s8_dx_d, s8_dx_q;
  logic [16:0] s8_eg_q;
  logic        s8_moved_q;

  assign en8        = !v8_q || out_ready_i;
  assign en7        = !v7_q || en8;
  assign en6        = !v6_q || en7;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    tb = in_i.bfull ? ONE_Q16 : {1'b0, in_i.bq};
    if (in_i.gfull) begin
      tg = ONE_Q16;
    end else if (in_i.gzero) begin
      tg = 17'd0;
    end else begin
      tg = {1'b0, in_i.gq};
    end
  end

  // round half up of cube / 2^32
  always_comb begin
    rb = s3_cb_q + 51'h0_8000_0000;
    rg = s3_cg_q + 51'h0_8000_0000;
  end

  always_comb begin
    dbits     = cfg_i.slide_delta;
    s5_mag_d  = (s4_eg_q >= s4_eb_q) ? (s4_eg_q - s4_eb_q) : (s4_eb_q - s4_eg_q);
    s5_dmag_d = dbits[23] ? (~dbits + 24'd1) : dbits;
    s5_neg_d  = (s4_eg_q < s4_eb_q) ^ dbits[23];
  end

  // round to nearest, ties away from zero, then clamp to the signed range
  always_comb begin
    rsum = 58'(s7_p_q) + 58'h80_0000;
    qmag = rsum[57:24];
    qneg = ~qmag + 34'd1;
    if (s7_neg_q) begin
      s8_dx_d = (qmag > 34'h0_8000_0000) ? 32'h8000_0000 : qneg[31:0];
    end else begin
      s8_dx_d = (qmag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qmag[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
      if (en8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_ib_q <= ONE_Q16 - tb;
      s1_ig_q <= ONE_Q16 - tg;
    end
    if (en2 && v1_q) begin
      s2_sb_q <= 34'(s1_ib_q) * 34'(s1_ib_q);
      s2_sg_q <= 34'(s1_ig_q) * 34'(s1_ig_q);
      s2_ib_q <= s1_ib_q;
      s2_ig_q <= s1_ig_q;
    end
    if (en3 && v2_q) begin
      s3_cb_q <= 51'(s2_sb_q) * 51'(s2_ib_q);
      s3_cg_q <= 51'(s2_sg_q) * 51'(s2_ig_q);
    end
    if (en4 && v3_q) begin
      s4_eb_q <= ONE_Q16 - rb[48:32];
      s4_eg_q <= ONE_Q16 - rg[48:32];
    end
    if (en5 && v4_q) begin
      s5_mag_q  <= s5_mag_d;
      s5_dmag_q <= s5_dmag_d;
      s5_neg_q  <= s5_neg_d;
      s5_eg_q   <= s4_eg_q;
    end
    if (en6 && v5_q) begin
      s6_p_q   <= 41'(s5_mag_q) * 41'(s5_dmag_q);
      s6_neg_q <= s5_neg_q;
      s6_eg_q  <= s5_eg_q;
    end
    if (en7 && v6_q) begin
      s7_p_q   <= 57'(s6_p_q) * 57'(cfg_i.trailing_q8_8);
      s7_neg_q <= s6_neg_q;
      s7_eg_q  <= s6_eg_q;
    end
    if (en8 && v7_q) begin
      s8_dx_q    <= s8_dx_d;
      s8_eg_q    <= s7_eg_q;
      s8_moved_q <= (s8_dx_d != 32'd0) || (s7_eg_q != 17'd0);
    end
  end

  assign out_valid_o   = v8_q;
  assign glyph_dx_o    = s8_dx_q;
  assign glyph_alpha_o = s8_eg_q;
  assign moved_o       = s8_moved_q;

endmodule

/* sv/staggered_glyph_ease_out.sv */
// Top level of the staggered glyph ease-out block: config registers and pipeline.
//
// One input transfer per glyph on s_axis: layer time, glyph index and glyph
// count. One result transfer per glyph on m_axis: horizontal offset (Q23.8,
// saturated), opacity (Q1.16 eased glyph progress) and the moved flag.
// Results leave in input order.
//
// Config: write cfg_we_i with cfg_idx_i / cfg_wdata_i; registers take effect
// on the next clock. Change them only while the pipeline is empty.
//
// Throughput is one transfer per cycle while m_axis_tready is high. The path
// to m_axis_tvalid has 5 front stages (multiplies, clamp, glyph start
// compare), 16 divider stages (one quotient bit per stage for the base and
// glyph progress) and 8 back stages (cube, offset product, round, saturate).
//
// Reset empties the pipeline and loads the register defaults.
// When m_axis_tready is low the last stage holds; earlier stages keep moving
// into empty slots, so s_axis_tready falls only once every stage is full.
module staggered_glyph_ease_out (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // time_us[31:0], glyph_index[43:32], glyph_count[56:44]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // glyph_dx[31:0], glyph_alpha[48:32], moved[49]
);
  import sge_pkg::*;

  localparam int unsigned DivSteps = 16;

  cfg_t        cfg_q;
  logic [31:0] time_us;
  logic [11:0] glyph_index;
  logic [12:0] glyph_count;
  logic [31:0] glyph_dx;
  logic [16:0] glyph_alpha;
  logic        moved;

  div_t        div_data [DivSteps+1];
  logic        div_valid [DivSteps+1];
  logic        div_ready [DivSteps+1];

  // Register file; writes to unused indexes fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DURATION:    cfg_q.duration_us     <= cfg_wdata_i;
        CFG_STAGGER:     cfg_q.stagger_q16     <= cfg_wdata_i[15:0];
        CFG_TRAILING:    cfg_q.trailing_q8_8   <= cfg_wdata_i[15:0];
        CFG_DELTA:       cfg_q.slide_delta     <= cfg_wdata_i[23:0];
        CFG_MANUAL_EN:   cfg_q.manual_enable   <= cfg_wdata_i[0];
        CFG_MANUAL_PROG: cfg_q.manual_progress <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  assign time_us     = s_axis_tdata[31:0];
  assign glyph_index = s_axis_tdata[43:32];
  assign glyph_count = s_axis_tdata[56:44];

  // Front: time select/clamp, span products, start compare.
  sge_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .time_i      (time_us),
    .idx_i       (glyph_index),
    .cnt_i       (glyph_count),
    .out_valid_o (div_valid[0]),
    .out_ready_i (div_ready[0]),
    .out_o       (div_data[0])
  );

  // Divider chain: one quotient bit per stage, MSB first.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    sge_div_stage u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[k]),
      .in_ready_o  (div_ready[k]),
      .in_i        (div_data[k]),
      .out_valid_o (div_valid[k+1]),
      .out_ready_i (div_ready[k+1]),
      .out_o       (div_data[k+1])
    );
  end

  // Back: easing, offset product, rounding and saturation; last stage is the
  // output register.
  sge_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (div_valid[DivSteps]),
    .in_ready_o    (div_ready[DivSteps]),
    .in_i          (div_data[DivSteps]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .glyph_dx_o    (glyph_dx),
    .glyph_alpha_o (glyph_alpha),
    .moved_o       (moved)
  );

  assign m_axis_tdata = {6'd0, moved, glyph_alpha, glyph_dx};

`ifndef SYNTHESIS
  // A ready sink must propagate ready all the way back to the input.
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the sink is ready");

  // An empty output stage leaves room for a new transfer.
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // Eased opacity never exceeds one.
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (glyph_alpha <= ONE_Q16))
    else $error("glyph_alpha above one");
`endif

endmodule
